// ===== rtl/core/floored_int_divide_modulo_assert.svh =====
// Assertion macros for the floored divider
`ifndef FLOORED_INT_DIVIDE_MODULO_ASSERT_SVH
`define FLOORED_INT_DIVIDE_MODULO_ASSERT_SVH
`ifndef SYNTHESIS
`define FDM_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FDM_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FDM_ASSERT_IMP(label, clk, rst_n, a, c)
`define FDM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/core/fdm_pkg.sv =====
package fdm_pkg;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MOD = 1'b1
  } op_t;

  typedef struct packed {
    logic              operation;
    logic signed [63:0] dividend;
    logic signed [63:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               zero_divisor;
  } out_item_t;

endpackage

// ===== rtl/core/floored_int_divide_modulo.sv =====
// An input register, a chain of restoring stages and an output register lie between accept and result valid.
// Throughput: one item per cycle; a chain of radix-16 restoring stages sets it.
// The whole pipeline holds when the result is not taken.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`include "floored_int_divide_modulo_assert.svh"
module floored_int_divide_modulo #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fdm_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fdm_pkg::out_item_t   out_data
);

  localparam int W    = DATA_WIDTH;
  localparam int BITS = 4;
  localparam int NST  = (W + BITS - 1) / BITS;
  localparam int QW   = NST * BITS;
  localparam int SW   = 5;

  // side bits: {mod, neg_a, neg_b, zero_b, minus_one}
  logic stall;
  assign stall    = out_valid && !out_ready;
  assign in_ready = !stall;

  // stage 0: magnitudes
  logic [W-1:0] a_w, b_w, ma_w, mb_w;
  logic         na_w, nb_w;
  assign a_w  = in_data.dividend[W-1:0];
  assign b_w  = in_data.divisor[W-1:0];
  assign na_w = a_w[W-1];
  assign nb_w = b_w[W-1];
  assign ma_w = na_w ? (~a_w + 1'b1) : a_w;
  assign mb_w = nb_w ? (~b_w + 1'b1) : b_w;

  logic          v0_r;
  logic [QW-1:0] ma0_r;
  logic [QW-1:0] mb0_r;
  logic [SW-1:0] s0_r;
  logic [QW-1:0] b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (!stall) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      ma0_r <= QW'(ma_w);
      mb0_r <= QW'(mb_w);
      b0_r  <= QW'(b_w);
      s0_r  <= {in_data.operation, na_w, nb_w, (b_w == '0), (b_w == '1)};
    end
  end

  logic          v_c   [NST+1];
  logic [QW-1:0] rem_c [NST+1];
  logic [QW-1:0] quo_c [NST+1];
  logic [QW-1:0] dvs_c [NST+1];
  logic [QW-1:0] aux_c [NST+1];
  logic [SW-1:0] sd_c  [NST+1];

  assign v_c[0]   = v0_r;
  assign rem_c[0] = '0;
  assign quo_c[0] = ma0_r;
  assign dvs_c[0] = mb0_r;
  assign aux_c[0] = b0_r;
  assign sd_c[0]  = s0_r;

  for (genvar g = 0; g < NST; g++) begin : g_st
    fdm_stage #(.W(QW), .BITS(BITS), .SW(SW)) u_st (
      .clk(clk), .rst_n(rst_n), .stall(stall),
      .vld_i(v_c[g]), .rem_i(rem_c[g]), .quo_i(quo_c[g]), .dvs_i(dvs_c[g]),
      .side_i(sd_c[g]), .aux_i(aux_c[g]),
      .vld_o(v_c[g+1]), .rem_o(rem_c[g+1]), .quo_o(quo_c[g+1]),
      .dvs_o(dvs_c[g+1]), .side_o(sd_c[g+1]), .aux_o(aux_c[g+1])
    );
  end

  // final stage: sign fix and floor correction
  logic [W-1:0] q_w, r_w, tq_w, tr_w, res_w, bb_w;
  logic         md, na, nb, zb, m1, adj;
  assign q_w  = quo_c[NST][W-1:0];
  assign r_w  = rem_c[NST][W-1:0];
  assign bb_w = aux_c[NST][W-1:0];
  assign {md, na, nb, zb, m1} = sd_c[NST];
  assign adj  = (na != nb) && (r_w != '0);
  assign tq_w = ((na != nb) ? (~q_w + 1'b1) : q_w) - W'(adj);
  assign tr_w = (na ? (~r_w + 1'b1) : r_w) + (adj ? bb_w : '0);

  always_comb begin
    if (zb) begin
      res_w = '0;
    end else if (m1) begin
      // minus-one divisor: the signed quotient is already the wrapped negation of a
      res_w = (md == fdm_pkg::OP_MOD) ? '0 : tq_w;
    end else begin
      res_w = (md == fdm_pkg::OP_MOD) ? tr_w : tq_w;
    end
  end

  logic          out_valid_r;
  logic [W-1:0]  res_r;
  logic          zd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= v_c[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      res_r <= res_w;
      zd_r  <= zb;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_data.result       = 64'(signed'(res_r));
  assign out_data.zero_divisor = zd_r;

  `FDM_ASSERT_IMP(a_zero_res, clk, rst_n, out_valid && out_data.zero_divisor, out_data.result == '0)
  `FDM_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `FDM_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready)

endmodule

// ===== rtl/core/fdm_stage.sv =====
// One restoring-division stage: BITS quotient bits per stage, with side info.
module fdm_stage #(
  parameter int W    = 64,
  parameter int BITS = 4,
  parameter int SW   = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           stall,
  input  logic           vld_i,
  input  logic [W-1:0]   rem_i,
  input  logic [W-1:0]   quo_i,
  input  logic [W-1:0]   dvs_i,
  input  logic [SW-1:0]  side_i,
  input  logic [W-1:0]   aux_i,
  output logic           vld_o,
  output logic [W-1:0]   rem_o,
  output logic [W-1:0]   quo_o,
  output logic [W-1:0]   dvs_o,
  output logic [SW-1:0]  side_o,
  output logic [W-1:0]   aux_o
);

  logic [W-1:0] rem_nxt, quo_nxt;
  logic         vld_r;
  logic [W-1:0] rem_r, quo_r, dvs_r, aux_r;
  logic [SW-1:0] side_r;

  always_comb begin
    logic [W:0] trial;
    logic [W-1:0] r, q;
    r = rem_i;
    q = quo_i;
    for (int i = 0; i < BITS; i++) begin
      trial = {r, q[W-1]} - {1'b0, dvs_i};
      if (!trial[W]) begin
        r = trial[W-1:0];
        q = {q[W-2:0], 1'b1};
      end else begin
        r = {r[W-2:0], q[W-1]};
        q = {q[W-2:0], 1'b0};
      end
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!stall) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      dvs_r  <= dvs_i;
      side_r <= side_i;
      aux_r  <= aux_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign dvs_o  = dvs_r;
  assign side_o = side_r;
  assign aux_o  = aux_r;

endmodule
